/* src/ast_pkg.sv */
// Shared constants, keyword tables, helper functions and control types of the tokenizer.
package ast_pkg;

    localparam int AST_MAX_LEN = 32;
    localparam int KW_W        = 56;   // seven upper-case characters, right-justified

    localparam logic [4:0] KIND_SYMBOL   = 5'd0;
    localparam logic [4:0] KIND_COLON    = 5'd1;
    localparam logic [4:0] KIND_COMMA    = 5'd2;
    localparam logic [4:0] KIND_INSTR    = 5'd3;
    localparam logic [4:0] KIND_REG      = 5'd4;
    localparam logic [4:0] KIND_DIR      = 5'd5;
    localparam logic [4:0] KIND_OPERATOR = 5'd6;
    localparam logic [4:0] KIND_LBRACE   = 5'd7;
    localparam logic [4:0] KIND_RBRACE   = 5'd8;
    localparam logic [4:0] KIND_LT       = 5'd9;
    localparam logic [4:0] KIND_GT       = 5'd10;
    localparam logic [4:0] KIND_LBRACKET = 5'd11;
    localparam logic [4:0] KIND_RBRACKET = 5'd12;
    localparam logic [4:0] KIND_AT       = 5'd13;
    localparam logic [4:0] KIND_STRING   = 5'd14;
    localparam logic [4:0] KIND_NUMBER   = 5'd15;
    localparam logic [4:0] KIND_ERROR    = 5'd16;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam int N_INSTR = 68;
    localparam int N_REG   = 82;
    localparam int N_DIR   = 5;

    localparam logic [KW_W-1:0] INSTR_TAB [N_INSTR] = '{
        "ADD", "AND", "CALL", "CLI", "CMP", "DIV", "HLT", "IN", "INC", "INT",
        "JA", "JAE", "JB", "JBE", "JC", "JCXZ", "JECXZ", "JRCXZ", "JE", "JG",
        "JGE", "JL", "JLE", "JNA", "JNAE", "JNB", "JNBE", "JNC", "JNE", "JNG",
        "JNGE", "JNL", "JNLE", "JNO", "JNP", "JNS", "JNZ", "JO", "JP", "JPE",
        "JPO", "JS", "JZ", "JMP", "LGDT", "LIDT", "LOOP", "MOV", "MUL", "OR",
        "OUT", "POP", "PUSH", "RDMSR", "REP", "RET", "SHL", "SHR", "STI", "SYSCALL",
        "TEST", "WRMSR", "XOR", "DB", "DW", "DD", "DQ", "TIMES"
    };

    localparam logic [KW_W-1:0] REG_TAB [N_REG] = '{
        "RAX", "EAX", "AX", "AH", "AL", "RBX", "EBX", "BX", "BH", "BL",
        "RCX", "ECX", "CX", "CH", "CL", "RDX", "EDX", "DX", "DH", "DL",
        "RSI", "ESI", "SI", "SIL", "RDI", "EDI", "DI", "DIL", "RSP", "ESP",
        "SP", "SPL", "RBP", "EBP", "BP", "BPL", "R8", "R8D", "R8W", "R8B",
        "R9", "R9D", "R9W", "R9B", "R10", "R10D", "R10W", "R10B", "R11", "R11D",
        "R11W", "R11B", "R12", "R12D", "R12W", "R12B", "R13", "R13D", "R13W", "R13B",
        "R14", "R14D", "R14W", "R14B", "R15", "R15D", "R15W", "R15B", "RIP", "EIP",
        "IP", "CS", "DS", "SS", "ES", "FS", "GS", "CR0", "CR2", "CR3",
        "CR4", "CR8"
    };

    localparam logic [KW_W-1:0] DIR_TAB [N_DIR] = '{
        "SECTION", "BITS", "IMPORT", "EXPORT", "ORG"
    };

    typedef struct packed {
        logic load_in;      // latch the input beat
        logic append;       // append the held byte to the lexeme
        logic open_quote;   // append the opening quote and enter a string
        logic flush_start;  // latch the token kind, rewind the replay index
        logic flush_string; // the token being flushed is a string
        logic rd;           // read the buffer at the replay index
        logic emit_buf;     // load a buffered character into the output
        logic idx_inc;      // advance the replay index
        logic flush_done;   // clear the pending lexeme and string flags
        logic drop_string;  // drop an unclosed string
        logic emit_punct;   // load the held byte as a one-character token
        logic emit_error;   // load the error beat and halt
    } ast_cmd_t;

    typedef struct packed {
        logic halted;
        logic in_quotes;
        logic len_zero;
        logic is_word;
        logic is_punct;
        logic is_quote;
        logic close_quote;
        logic eol;
        logic word_err;
        logic last_idx;
        logic out_free;
    } ast_sts_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || c == 8'h5F || c == 8'h21 || c == 8'h3F || c == 8'h2E || c == 8'h23;
    endfunction

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        k = {1'b0, KIND_SYMBOL};
        unique case (c)
            8'h3A:                      k = {1'b1, KIND_COLON};
            8'h2C:                      k = {1'b1, KIND_COMMA};
            8'h2B, 8'h2D, 8'h2A, 8'h2F: k = {1'b1, KIND_OPERATOR};
            8'h7B:                      k = {1'b1, KIND_LBRACE};
            8'h7D:                      k = {1'b1, KIND_RBRACE};
            8'h3C:                      k = {1'b1, KIND_LT};
            8'h3E:                      k = {1'b1, KIND_GT};
            8'h5B:                      k = {1'b1, KIND_LBRACKET};
            8'h5D:                      k = {1'b1, KIND_RBRACKET};
            8'h40:                      k = {1'b1, KIND_AT};
            default:                    k = {1'b0, KIND_SYMBOL};
        endcase
        return k;
    endfunction

endpackage

/* src/ast_datapath.sv */
// Lexeme buffer, class flags, keyword matcher and output register of the tokenizer.
module ast_datapath
    import ast_pkg::*;
#(
    parameter int MAX_LEN = AST_MAX_LEN
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ast_cmd_t   cmd,
    output ast_sts_t   sts,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic [5:0] m_tuser,
    output logic       m_tlast
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);

    logic [7:0]       mem [MAX_LEN];
    logic [7:0]       ch_reg;
    logic             eol_reg;
    logic [LEN_W-1:0] len_reg;
    logic             inq_reg;
    logic             esc_reg;
    logic             dec_reg, hexok_reg, pfx_reg, lead_reg, zero0_reg;
    logic             ovf_reg;
    logic             halted_reg;
    logic [KW_W-1:0]  word_up_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [4:0]       kind_reg;
    logic [7:0]       rd_data_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic [5:0]       m_user_reg;
    logic             m_last_reg;

    logic [7:0] up_ch;
    logic       dig, room, out_free, any_instr, any_reg, any_dir, kw_ok, is_num;
    logic [4:0] word_kind;
    logic [5:0] pk;

    assign up_ch    = to_upper(ch_reg);
    assign dig      = is_digit(ch_reg);
    assign room     = len_reg < LEN_W'(MAX_LEN);
    assign out_free = !m_valid_reg || m_tready;
    assign pk       = punct_kind(ch_reg);
    assign kw_ok    = !ovf_reg && len_reg <= LEN_W'(7);

    always_comb begin
        any_instr = 1'b0;
        any_reg   = 1'b0;
        any_dir   = 1'b0;
        for (int k = 0; k < N_INSTR; k++) any_instr |= (word_up_reg == INSTR_TAB[k]);
        for (int k = 0; k < N_REG; k++)   any_reg   |= (word_up_reg == REG_TAB[k]);
        for (int k = 0; k < N_DIR; k++)   any_dir   |= (word_up_reg == DIR_TAB[k]);
    end

    assign is_num = dec_reg || (pfx_reg && hexok_reg);

    always_comb begin
        priority if (kw_ok && any_instr) word_kind = KIND_INSTR;
        else if (kw_ok && any_reg)       word_kind = KIND_REG;
        else if (kw_ok && any_dir)       word_kind = KIND_DIR;
        else if (is_num)                 word_kind = KIND_NUMBER;
        else if (lead_reg)               word_kind = KIND_ERROR;
        else                             word_kind = KIND_SYMBOL;
    end

    always_comb begin
        sts.halted      = halted_reg;
        sts.in_quotes   = inq_reg;
        sts.len_zero    = len_reg == '0;
        sts.is_word     = is_word_char(ch_reg);
        sts.is_punct    = pk[5];
        sts.is_quote    = ch_reg == CH_QUOTE;
        sts.close_quote = !esc_reg && ch_reg == CH_QUOTE;
        sts.eol         = eol_reg;
        sts.word_err    = word_kind == KIND_ERROR;
        sts.last_idx    = LEN_W'(idx_reg) == len_reg - LEN_W'(1);
        sts.out_free    = out_free;
    end

    // buffer storage, no reset
    always_ff @(posedge aclk) begin
        if ((cmd.append || cmd.open_quote) && room) begin
            mem[len_reg[IDX_W-1:0]] <= ch_reg;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ch_reg  <= s_tdata;
            eol_reg <= s_tlast;
        end
        if (cmd.append || cmd.open_quote) begin
            if (len_reg == '0) begin
                word_up_reg <= {{(KW_W-8){1'b0}}, up_ch};
            end else begin
                word_up_reg <= {word_up_reg[KW_W-9:0], up_ch};
            end
        end
        if (cmd.flush_start) begin
            kind_reg <= cmd.flush_string ? KIND_STRING : word_kind;
            idx_reg  <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.emit_buf) begin
            m_data_reg <= rd_data_reg;
            m_user_reg <= {ovf_reg, kind_reg};
            m_last_reg <= sts.last_idx;
        end else if (cmd.emit_punct) begin
            m_data_reg <= ch_reg;
            m_user_reg <= {1'b0, pk[4:0]};
            m_last_reg <= 1'b1;
        end else if (cmd.emit_error) begin
            m_data_reg <= 8'h00;
            m_user_reg <= {1'b0, KIND_ERROR};
            m_last_reg <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            inq_reg     <= 1'b0;
            esc_reg     <= 1'b0;
            dec_reg     <= 1'b0;
            hexok_reg   <= 1'b0;
            pfx_reg     <= 1'b0;
            lead_reg    <= 1'b0;
            zero0_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.append || cmd.open_quote) begin
                if (!ovf_reg && len_reg == '0) begin
                    hexok_reg <= 1'b1;
                    dec_reg   <= dig;
                    lead_reg  <= dig;
                    pfx_reg   <= 1'b0;
                    zero0_reg <= ch_reg == 8'h30;
                end else if (!ovf_reg && len_reg == LEN_W'(1)) begin
                    if (!dig) dec_reg <= 1'b0;
                    if (zero0_reg && (ch_reg == 8'h78 || ch_reg == 8'h58)) pfx_reg <= 1'b1;
                end else begin
                    if (!dig) dec_reg <= 1'b0;
                    if (!is_hex(ch_reg)) hexok_reg <= 1'b0;
                end
                if (room) begin
                    len_reg <= len_reg + LEN_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            // escape tracking inside a string
            if (cmd.append && inq_reg) begin
                if (ch_reg == CH_BACKSLASH) begin
                    esc_reg <= !esc_reg;
                end else begin
                    esc_reg <= 1'b0;
                end
            end
            if (cmd.open_quote) begin
                inq_reg <= 1'b1;
                esc_reg <= 1'b0;
            end
            if (cmd.flush_done || cmd.drop_string || cmd.emit_error) begin
                len_reg   <= '0;
                dec_reg   <= 1'b0;
                hexok_reg <= 1'b0;
                pfx_reg   <= 1'b0;
                lead_reg  <= 1'b0;
                ovf_reg   <= 1'b0;
                inq_reg   <= 1'b0;
                esc_reg   <= 1'b0;
            end
            if (cmd.emit_error) begin
                halted_reg <= 1'b1;
            end
            if (cmd.emit_buf || cmd.emit_punct || cmd.emit_error) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* src/ast_ctrl.sv */
// Sequencing state machine of the tokenizer.
module ast_ctrl
    import ast_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ast_sts_t sts,
    output ast_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_AFTER  = 3'd2;
    localparam logic [2:0] ST_PUNCT  = 3'd3;
    localparam logic [2:0] ST_EOL    = 3'd4;
    localparam logic [2:0] ST_RD     = 3'd5;
    localparam logic [2:0] ST_WR     = 3'd6;
    localparam logic [2:0] ST_ERR    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;

    assign s_tready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.halted) begin
                    state_next = ST_IDLE;
                end else if (sts.in_quotes) begin
                    cmd.append = 1'b1;
                    if (sts.close_quote) begin
                        cmd.flush_start  = 1'b1;
                        cmd.flush_string = 1'b1;
                        ret_next         = ST_EOL;
                        state_next       = ST_RD;
                    end else begin
                        state_next = ST_EOL;
                    end
                end else if (sts.is_word) begin
                    cmd.append = 1'b1;
                    state_next = ST_EOL;
                end else if (!sts.len_zero) begin
                    if (sts.word_err) begin
                        state_next = ST_ERR;
                    end else begin
                        cmd.flush_start = 1'b1;
                        ret_next        = ST_AFTER;
                        state_next      = ST_RD;
                    end
                end else begin
                    state_next = ST_AFTER;
                end
            end
            ST_AFTER: begin
                if (sts.is_punct) begin
                    state_next = ST_PUNCT;
                end else begin
                    cmd.open_quote = sts.is_quote;
                    state_next     = ST_EOL;
                end
            end
            ST_PUNCT: begin
                if (sts.out_free) begin
                    cmd.emit_punct = 1'b1;
                    state_next     = ST_EOL;
                end
            end
            ST_EOL: begin
                state_next = ST_IDLE;
                if (sts.eol) begin
                    if (sts.in_quotes) begin
                        cmd.drop_string = 1'b1;
                    end else if (!sts.len_zero) begin
                        if (sts.word_err) begin
                            state_next = ST_ERR;
                        end else begin
                            cmd.flush_start = 1'b1;
                            ret_next        = ST_IDLE;
                            state_next      = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                if (sts.out_free) begin
                    cmd.emit_buf = 1'b1;
                    if (sts.last_idx) begin
                        cmd.flush_done = 1'b1;
                        state_next     = ret_reg;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            ST_ERR: begin
                if (sts.out_free) begin
                    cmd.emit_error = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

/* src/assembly_source_tokenizer.sv */
// Top level of the assembly source tokenizer: controller plus datapath.
// Sequence: accept a beat, decode it in the cycle after; then a word character goes to
//   end-of-line, an ignored byte or opening quote via after, a punctuation byte via after
//   and punctuation. A flushed token replays its buffer a character at a time (read, write).
// Reset: aresetn (synchronous, active low) clears the lexeme length, string and
//   class flags, the halt flag and the output valid; buffer contents stay as they are.
module assembly_source_tokenizer
    import ast_pkg::*;
#(
    parameter int MAX_LEN = AST_MAX_LEN
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // end_of_line
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] token_char
    output logic [5:0] m_tuser,   // [4:0] token_kind, [5] truncated
    output logic       m_tlast    // last_of_token
);

    ast_cmd_t cmd;
    ast_sts_t sts;

    // Controller: accept one beat, walk through decode, flush, punctuation, error and
    // end-of-line handling, then return to accept the next beat.
    ast_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: hold the lexeme and its flags, classify it, and drive the
    // output register that parts the result side from the input side.
    ast_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
